>>> rtl/ust_pkg.sv
// Shared types and codes for the unsorted set table.
// Request and result payload structs, request and status codes, cell control.
// No dependencies.
`default_nettype none

package ust_pkg;

	localparam int DEPTH_DEF     = 64;
	localparam int KEY_WIDTH_DEF = 32;
	localparam int CFG_W         = 7;

	localparam logic [CFG_W-1:0] MAX_ITEMS_RST = 7'd64;

	// Request codes
	localparam logic [2:0] REQ_INSERT = 3'd0;
	localparam logic [2:0] REQ_DELETE = 3'd1;
	localparam logic [2:0] REQ_FIND   = 3'd2;
	localparam logic [2:0] REQ_READ   = 3'd3;
	localparam logic [2:0] REQ_CLEAR  = 3'd4;

	// Status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_FULL      = 3'd1;
	localparam logic [2:0] ST_DUPLICATE = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_RANGE     = 3'd4;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [31:0] key;
		logic [5:0]  position;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [5:0]  found_position;
		logic [31:0] read_key;
		logic [6:0]  entry_count;
		logic        empty_flag;
		logic        full_flag;
	} rsp_t;

	typedef struct packed {
		logic load_new; // take the appended key
		logic shift;    // take the key of the next cell up
	} cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/unsorted_set_table.sv
// Unsorted set table: a transferred request is held in the request registers, and the result is
// registered once the result register can take it. One request at a time: every cell compares
// against the incoming key at the transfer edge, and the row is updated with the result before
// another key may be compared. A stalled result holds the request in flight until the result
// register frees. Reset clears the count, the busy flag and the result valid, and sets the limit
// to 64; cell contents are left undefined and are never read before they are written.
`default_nettype none

module unsorted_set_table #(
	parameter int DEPTH     = ust_pkg::DEPTH_DEF,
	parameter int KEY_WIDTH = ust_pkg::KEY_WIDTH_DEF
) (
	input  wire                         clk,
	input  wire                         arst_n,
	// request channel
	input  wire                         req_valid,
	output logic                        req_stall,
	input  wire ust_pkg::req_t          req_data,
	// result channel
	output logic                        rsp_valid,
	input  wire                         rsp_stall,
	output ust_pkg::rsp_t               rsp_data,
	// limit register
	input  wire                         cfg_we,
	input  wire  [ust_pkg::CFG_W-1:0]   cfg_wdata
);
	import ust_pkg::*;

	// Stored key width: the key field is 32 bits, so never more than that.
	localparam int KW = (KEY_WIDTH > 32) ? 32 : KEY_WIDTH;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);
	localparam int LW = (CW > CFG_W) ? CW : CFG_W;
	localparam int IW = (AW > 6) ? AW : 6;

	// Control and configuration
	logic [CFG_W-1:0] max_items_q;
	logic [CW-1:0]    count_q;
	logic             busy_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	// Request held while the row acts on it
	logic [2:0]       req_s1;
	logic [KW-1:0]    key_s1;
	logic [5:0]       pos_s1;
	logic [DEPTH-1:0] match_s1;
	logic [KW-1:0]    rd_s1;

	// Row of cells
	logic [KW-1:0]    cell_key [DEPTH];
	logic [DEPTH-1:0] cell_match;
	cell_ctrl_t       cell_ctrl [DEPTH];

	logic             accept;
	logic             done;
	logic [KW-1:0]    in_key;
	logic [KW-1:0]    rd_sel;

	logic [AW-1:0]    hit_pos;
	logic             hit;
	logic [LW-1:0]    limit;
	logic             ins_en;
	logic             del_en;
	logic [CW-1:0]    count_nxt;
	rsp_t             rsp_nxt;

	assign in_key    = req_data.key[KW-1:0];
	assign accept    = req_valid && !busy_q;
	// Finish only when the result register can take the outcome.
	assign done      = busy_q && (!rsp_valid_q || !rsp_stall);
	assign req_stall = busy_q;
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// ------------------------------------------------------------------
	// Cells: each compares its key with the incoming one, and moves down
	// one place or takes the appended key when told.
	// ------------------------------------------------------------------
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [KW-1:0] up_key;

		if (i == DEPTH - 1) begin : g_top
			assign up_key = cell_key[i];
		end else begin : g_mid
			assign up_key = cell_key[i+1];
		end

		assign cell_ctrl[i].load_new = done && ins_en && (count_q == CW'(i));
		assign cell_ctrl[i].shift    = done && del_en && (AW'(i) >= hit_pos);

		ust_cell #(
			.KW(KW)
		) u_cell (
			.clk    (clk),
			.cmp_key(in_key),
			.new_key(key_s1),
			.up_key (up_key),
			.ctrl   (cell_ctrl[i]),
			.key    (cell_key[i]),
			.match  (cell_match[i])
		);
	end

	// Pick the key at the requested position: AND-OR over the row.
	always_comb begin
		rd_sel = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (IW'(req_data.position) == IW'(i)) begin
				rd_sel = rd_sel | cell_key[i];
			end
		end
	end

	// Keys held are distinct, so at most one live cell matches: encode by OR.
	always_comb begin
		hit_pos = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (match_s1[i]) begin
				hit_pos = hit_pos | AW'(i);
			end
		end
	end

	assign hit   = |match_s1;
	assign limit = (LW'(max_items_q) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(max_items_q);

	// ------------------------------------------------------------------
	// Decide the outcome of the held request.
	// ------------------------------------------------------------------
	always_comb begin
		ins_en    = 1'b0;
		del_en    = 1'b0;
		count_nxt = count_q;
		rsp_nxt   = '0;

		unique case (req_s1)
			REQ_INSERT: begin
				if (LW'(count_q) >= limit) begin
					rsp_nxt.status = ST_FULL;
				end else if (hit) begin
					rsp_nxt.status = ST_DUPLICATE;
				end else if (count_q < CW'(DEPTH)) begin
					ins_en    = 1'b1;
					count_nxt = count_q + CW'(1);
				end
			end
			REQ_DELETE: begin
				if (!hit) begin
					rsp_nxt.status = ST_NOT_FOUND;
				end else begin
					del_en    = 1'b1;
					count_nxt = count_q - CW'(1);
				end
			end
			REQ_FIND: begin
				if (hit) begin
					rsp_nxt.found_position = 6'(hit_pos);
				end else begin
					rsp_nxt.status = ST_NOT_FOUND;
				end
			end
			REQ_READ: begin
				if (LW'(pos_s1) < LW'(count_q)) begin
					rsp_nxt.read_key = 32'(rd_s1);
				end else begin
					rsp_nxt.status = ST_RANGE;
				end
			end
			REQ_CLEAR: begin
				count_nxt = '0;
			end
			default: begin
				// unused codes: no change
			end
		endcase

		rsp_nxt.entry_count = 7'(count_nxt);
		rsp_nxt.empty_flag  = (count_nxt == '0);
		rsp_nxt.full_flag   = (LW'(count_nxt) >= limit);
	end

	// ------------------------------------------------------------------
	// Registers
	// ------------------------------------------------------------------
	// Capture the request, the live match vector and the addressed key.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req_data.req_type;
			key_s1 <= in_key;
			pos_s1 <= req_data.position;
			rd_s1  <= rd_sel;
			for (int i = 0; i < DEPTH; i++) begin
				match_s1[i] <= cell_match[i] && (CW'(i) < count_q);
			end
		end
	end

	// Hold the result until its transfer.
	always_ff @(posedge clk) begin
		if (done) begin
			rsp_q <= rsp_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_items_q <= MAX_ITEMS_RST;
			count_q     <= '0;
			busy_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_items_q <= cfg_wdata;
			end
			if (accept) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end
			if (done) begin
				count_q     <= count_nxt;
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/ust_cell.sv
// One storage cell of the unsorted set table: holds a key, compares it,
// loads a new key or its upper neighbour's key. Depends on ust_pkg.
`default_nettype none

module ust_cell #(
	parameter int KW = 32
) (
	input  wire                     clk,
	input  wire  [KW-1:0]           cmp_key,
	input  wire  [KW-1:0]           new_key,
	input  wire  [KW-1:0]           up_key,
	input  wire ust_pkg::cell_ctrl_t ctrl,
	output logic [KW-1:0]           key,
	output logic                    match
);
	import ust_pkg::*;

	logic [KW-1:0] key_q;

	always_ff @(posedge clk) begin
		if (ctrl.load_new) begin
			key_q <= new_key;
		end else if (ctrl.shift) begin
			key_q <= up_key;
		end
	end

	assign key   = key_q;
	assign match = (key_q == cmp_key);

endmodule

`default_nettype wire

>>> rtl/ust_checker.sv
// Port-level checks for the unsorted set table, bound to the top level.
// Depends on ust_pkg and unsorted_set_table.
`default_nettype none

module ust_checker (
	input wire                clk,
	input wire                arst_n,
	input wire                req_valid,
	input wire                req_stall,
	input wire                rsp_valid,
	input wire                rsp_stall,
	input wire ust_pkg::rsp_t rsp_data
);
	import ust_pkg::*;

	// One request at a time: a transfer blocks the next cycle.
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while previous one in flight");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data.empty_flag == (rsp_data.entry_count == 7'd0))
		else $error("empty flag disagrees with count");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.status == ST_FULL |-> rsp_data.full_flag)
		else $error("full status without full flag");

	a_fail_no_key: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.status != ST_OK |-> rsp_data.read_key == 32'd0)
		else $error("key returned on a failed request");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
		else $error("stalled result changed");

endmodule

bind unsorted_set_table ust_checker u_ust_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_stall(req_stall),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp_data (rsp_data)
);

`default_nettype wire
